>>> rtl/dtrc_pkg.sv
// ----------------------------------------------------------------------------
// dtrc_pkg
// Shared widths, reset values, register indexes and stage types for the
// depth-to-rainbow colour pipeline.
// ----------------------------------------------------------------------------
package dtrc_pkg;

  localparam int DEPTH_W            = 16;
  localparam int SCALE_W            = 24;
  localparam int CHAN_W             = 8;
  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = 24;
  localparam int DEPTH_BITS_DEFAULT = 16;

  localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST = 16'd600;
  localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 16'd3600;
  localparam logic [SCALE_W-1:0] SCALE_RST     = 24'd5571;

  // product of depth and Q8.16 scale, and its Q.8 view
  localparam int PROD_W = DEPTH_W + SCALE_W;
  localparam int FRAC_DROP = 8;

  // inverted value v = 256.0 - s in Q.8, held 1 .. 65536 when not saturated
  localparam int V_W = 17;
  localparam logic [V_W-1:0] V_ONE     = 17'h10000;
  localparam logic [V_W-1:0] V_BLACK   = 17'd65280;
  localparam logic [V_W-1:0] SEG1_BASE = 17'd13056;
  localparam logic [V_W-1:0] SEG2_BASE = 17'd26112;
  localparam logic [V_W-1:0] SEG3_BASE = 17'd39168;
  localparam logic [V_W-1:0] SEG4_BASE = 17'd52224;

  // offset within a segment, Q.8, never above 51.0
  localparam int W_W = 14;
  localparam logic [W_W-1:0] SEG_SPAN = 14'd13056;

  // rounded segments: floor((w*K + 51*128) / (51*256)) = floor(x / 51)
  // with x = (w*K + 51*128) >> 8
  localparam int NUM_W = 21;
  localparam int X_W   = 13;
  localparam logic [NUM_W-1:0] HALF_TERM = 21'd6528;
  localparam int RECIP_W = 11;
  localparam logic [RECIP_W-1:0] RECIP_51 = 11'd1285;
  localparam int XR_W = X_W + RECIP_W;
  localparam int REM_W = 14;
  localparam logic [REM_W-1:0] SEG_STEP = 14'd51;

  localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;
  localparam logic [CHAN_W-1:0] CHAN_HALF = 8'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DEPTH = 2'd0,
    CFG_MAX_DEPTH = 2'd1,
    CFG_SCALE     = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SEG_BLACK,
    SEG_RISE_G,     // blue full, green rising
    SEG_FALL_B,     // blue falling, green full
    SEG_RISE_R,     // green full, red rising
    SEG_FALL_G_HI,  // red full, green falling 255 -> 127
    SEG_FALL_G_LO   // red full, green falling 127 -> 0
  } seg_t;

  typedef struct packed {
    seg_t           seg;
    logic [W_W-1:0] w;
  } seg_beat_t;

endpackage

>>> rtl/dtrc_clamp.sv
// ----------------------------------------------------------------------------
// dtrc_clamp
// First stage: masks the raw depth and applies the min/max range rules.
// ----------------------------------------------------------------------------
module dtrc_clamp
  import dtrc_pkg::*;
#(
  parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DEPTH_W-1:0] depth,
  input  logic [DEPTH_W-1:0] min_depth,
  input  logic [DEPTH_W-1:0] max_depth,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DEPTH_W-1:0] t
);

  logic [DEPTH_W-1:0] d;
  logic [DEPTH_W-1:0] t_nxt;
  logic [DEPTH_W-1:0] t_r;
  logic               vld_r;

  assign d = DEPTH_W'(depth[DEPTH_BITS-1:0]);

  always_comb begin
    if (d != '0 && d < min_depth) begin
      t_nxt = min_depth;
    end else if (d > max_depth) begin
      t_nxt = '0;
    end else if (d == '0) begin
      t_nxt = '0;
    end else begin
      t_nxt = d - min_depth;
    end
  end

  assign in_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign t         = t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      t_r <= t_nxt;
    end
  end

endmodule

>>> rtl/dtrc_scale.sv
// ----------------------------------------------------------------------------
// dtrc_scale
// Two stages: depth times Q8.16 scale, then inversion to 256 - s and
// selection of the colour segment with the offset inside it.
// ----------------------------------------------------------------------------
module dtrc_scale
  import dtrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DEPTH_W-1:0] t,
  input  logic [SCALE_W-1:0] scale_factor,
  output logic               out_valid,
  input  logic               out_ready,
  output seg_beat_t          seg_beat
);

  logic [PROD_W-1:0]  prod;
  logic               big_nxt;
  logic [DEPTH_W-1:0] s_nxt;
  logic               big_r;
  logic [DEPTH_W-1:0] s_r;
  logic               vld2_r;
  logic               rdy2;

  logic [V_W-1:0]     v;
  seg_beat_t          beat_nxt;
  seg_beat_t          beat_r;
  logic               vld3_r;
  logic               rdy3;

  // stage 2: multiply, keep Q.8 and a flag for s >= 256.0
  assign prod    = PROD_W'(t) * PROD_W'(scale_factor);
  assign big_nxt = |prod[PROD_W-1:DEPTH_W+FRAC_DROP];
  assign s_nxt   = prod[DEPTH_W+FRAC_DROP-1:FRAC_DROP];

  // stage 3: invert and pick segment
  assign v = V_ONE - V_W'(s_r);

  always_comb begin
    beat_nxt.seg = SEG_BLACK;
    beat_nxt.w   = '0;
    if (big_r || v >= V_BLACK) begin
      beat_nxt.seg = SEG_BLACK;
    end else if (v <= SEG1_BASE) begin
      beat_nxt.seg = SEG_RISE_G;
      beat_nxt.w   = W_W'(v);
    end else if (v <= SEG2_BASE) begin
      beat_nxt.seg = SEG_FALL_B;
      beat_nxt.w   = W_W'(v - SEG1_BASE);
    end else if (v <= SEG3_BASE) begin
      beat_nxt.seg = SEG_RISE_R;
      beat_nxt.w   = W_W'(v - SEG2_BASE);
    end else if (v <= SEG4_BASE) begin
      beat_nxt.seg = SEG_FALL_G_HI;
      beat_nxt.w   = W_W'(v - SEG3_BASE);
    end else begin
      beat_nxt.seg = SEG_FALL_G_LO;
      beat_nxt.w   = W_W'(v - SEG4_BASE);
    end
  end

  assign rdy3      = !vld3_r || out_ready;
  assign rdy2      = !vld2_r || rdy3;
  assign in_ready  = rdy2;
  assign out_valid = vld3_r;
  assign seg_beat  = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      if (rdy2) begin
        vld2_r <= in_valid;
      end
      if (rdy3) begin
        vld3_r <= vld2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy2) begin
      big_r <= big_nxt;
      s_r   <= s_nxt;
    end
    if (vld2_r && rdy3) begin
      beat_r <= beat_nxt;
    end
  end

  // a coloured beat always has a nonzero offset no larger than its segment's span
  a_w_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (vld3_r && beat_r.seg != SEG_BLACK) |-> (beat_r.w != '0 && beat_r.w <= SEG_SPAN))
    else $error("segment offset out of range");

  // a saturated product never yields a coloured beat
  a_big_black: assert property (@(posedge clk) disable iff (!rst_n)
    (vld2_r && big_r && rdy3) |=> (beat_r.seg == SEG_BLACK))
    else $error("saturated scale produced a colour");

endmodule

>>> rtl/dtrc_colour.sv
// ----------------------------------------------------------------------------
// dtrc_colour
// Three stages: linear ramps and rounding numerators, reciprocal multiply
// by 1/51, then remainder correction and channel assembly.
// ----------------------------------------------------------------------------
module dtrc_colour
  import dtrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  seg_beat_t         seg_beat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAN_W-1:0] chan0,
  output logic [CHAN_W-1:0] chan1,
  output logic [CHAN_W-1:0] chan2
);

  // stage 4
  logic [W_W+2:0]    w5;
  logic [NUM_W-1:0]  w128;
  logic [NUM_W-1:0]  num;
  logic [CHAN_W-1:0] lin_nxt;
  logic [X_W-1:0]    x_nxt;
  seg_t              seg4_r;
  logic [CHAN_W-1:0] lin4_r;
  logic [X_W-1:0]    x4_r;
  logic              vld4_r;
  logic              rdy4;

  // stage 5
  logic [XR_W-1:0]   xr;
  seg_t              seg5_r;
  logic [CHAN_W-1:0] lin5_r;
  logic [X_W-1:0]    x5_r;
  logic [CHAN_W-1:0] q0_r;
  logic              vld5_r;
  logic              rdy5;

  // stage 6
  logic [REM_W-1:0]  q51;
  logic [REM_W-1:0]  rem;
  logic [CHAN_W-1:0] q;
  logic [CHAN_W-1:0] c0_nxt;
  logic [CHAN_W-1:0] c1_nxt;
  logic [CHAN_W-1:0] c2_nxt;
  logic [CHAN_W-1:0] c0_r;
  logic [CHAN_W-1:0] c1_r;
  logic [CHAN_W-1:0] c2_r;
  logic              vld6_r;
  logic              rdy6;

  assign w5      = (W_W+3)'(seg_beat.w) * (W_W+3)'(5);
  assign lin_nxt = w5[CHAN_W+7:8];
  assign w128    = {seg_beat.w, 7'd0};
  assign num     = ((seg_beat.seg == SEG_FALL_G_LO) ? (w128 - NUM_W'(seg_beat.w)) : w128)
                   + HALF_TERM;
  assign x_nxt   = num[NUM_W-1:NUM_W-X_W];

  // q0 is floor(x/51) or one short of it
  assign xr = XR_W'(x4_r) * XR_W'(RECIP_51);

  assign q51 = REM_W'(q0_r) * SEG_STEP;
  assign rem = REM_W'(x5_r) - q51;
  assign q   = q0_r + CHAN_W'(rem >= SEG_STEP);

  always_comb begin
    c0_nxt = '0;
    c1_nxt = '0;
    c2_nxt = '0;
    case (seg5_r)
      SEG_RISE_G: begin
        c0_nxt = CHAN_FULL;
        c1_nxt = lin5_r;
      end
      SEG_FALL_B: begin
        c0_nxt = CHAN_FULL - lin5_r;
        c1_nxt = CHAN_FULL;
      end
      SEG_RISE_R: begin
        c1_nxt = CHAN_FULL;
        c2_nxt = lin5_r;
      end
      SEG_FALL_G_HI: begin
        c1_nxt = CHAN_FULL - q;
        c2_nxt = CHAN_FULL;
      end
      SEG_FALL_G_LO: begin
        c1_nxt = CHAN_HALF - q;
        c2_nxt = CHAN_FULL;
      end
      default: begin
        c0_nxt = '0;
      end
    endcase
  end

  assign rdy6      = !vld6_r || out_ready;
  assign rdy5      = !vld5_r || rdy6;
  assign rdy4      = !vld4_r || rdy5;
  assign in_ready  = rdy4;
  assign out_valid = vld6_r;
  assign chan0     = c0_r;
  assign chan1     = c1_r;
  assign chan2     = c2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else begin
      if (rdy4) begin
        vld4_r <= in_valid;
      end
      if (rdy5) begin
        vld5_r <= vld4_r;
      end
      if (rdy6) begin
        vld6_r <= vld5_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy4) begin
      seg4_r <= seg_beat.seg;
      lin4_r <= lin_nxt;
      x4_r   <= x_nxt;
    end
    if (vld4_r && rdy5) begin
      seg5_r <= seg4_r;
      lin5_r <= lin4_r;
      x5_r   <= x4_r;
      q0_r   <= xr[XR_W-1:XR_W-CHAN_W];
    end
    if (vld5_r && rdy6) begin
      c0_r <= c0_nxt;
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
    end
  end

  // reciprocal estimate is at most one short
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vld5_r && (seg5_r == SEG_FALL_G_HI || seg5_r == SEG_FALL_G_LO))
      |-> (q51 <= REM_W'(x5_r) && rem < (SEG_STEP + SEG_STEP)))
    else $error("divide-by-51 correction out of range");

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vld5_r && (seg5_r == SEG_FALL_G_HI || seg5_r == SEG_FALL_G_LO)) |-> (q <= 8'd128))
    else $error("rounded segment term too large");

endmodule

>>> rtl/depth_to_rainbow_color_unit.sv
// ----------------------------------------------------------------------------
// depth_to_rainbow_color_unit
// Depth pixel to BGR rainbow pseudocolour, six-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and gives one
// colour pixel per pixel. Stages: range clamp, 16x24 scale multiply,
// inversion and segment select, ramp and rounding numerators, multiply by
// 1/51, then correction and channel assembly. Back-pressure on the output
// holds the pipe; empty stages keep filling, so up to six beats are held in
// flight. min_depth, max_depth and scale_factor (Q8.16, expected
// 255/(max-min)) are to be written by the user through the cfg port only
// while no pixels are in the pipe; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module depth_to_rainbow_color_unit
  import dtrc_pkg::*;
#(
  parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DEPTH_W-1:0]    in_tdata,    // [15:0] depth_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [3*CHAN_W-1:0]   out_tdata,   // [7:0] chan0, [15:8] chan1, [23:16] chan2
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [DEPTH_W-1:0] min_depth_r;
  logic [DEPTH_W-1:0] max_depth_r;
  logic [SCALE_W-1:0] scale_factor_r;

  logic               clamp_valid;
  logic               clamp_ready;
  logic [DEPTH_W-1:0] clamp_t;
  logic               seg_valid;
  logic               seg_ready;
  seg_beat_t          seg_beat;
  logic [CHAN_W-1:0]  chan0;
  logic [CHAN_W-1:0]  chan1;
  logic [CHAN_W-1:0]  chan2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_depth_r    <= MIN_DEPTH_RST;
      max_depth_r    <= MAX_DEPTH_RST;
      scale_factor_r <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_DEPTH: min_depth_r    <= cfg_wdata[DEPTH_W-1:0];
        CFG_MAX_DEPTH: max_depth_r    <= cfg_wdata[DEPTH_W-1:0];
        CFG_SCALE:     scale_factor_r <= cfg_wdata[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dtrc_clamp #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_clamp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .depth     (in_tdata),
    .min_depth (min_depth_r),
    .max_depth (max_depth_r),
    .out_valid (clamp_valid),
    .out_ready (clamp_ready),
    .t         (clamp_t)
  );

  dtrc_scale u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (clamp_valid),
    .in_ready     (clamp_ready),
    .t            (clamp_t),
    .scale_factor (scale_factor_r),
    .out_valid    (seg_valid),
    .out_ready    (seg_ready),
    .seg_beat     (seg_beat)
  );

  dtrc_colour u_colour (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (seg_valid),
    .in_ready  (seg_ready),
    .seg_beat  (seg_beat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .chan0     (chan0),
    .chan1     (chan1),
    .chan2     (chan2)
  );

  assign out_tdata = {chan2, chan1, chan0};

  // the input only stalls when the whole pipe is full behind a stalled output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output back-pressure");

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the depth-to-rainbow colour unit.
// ----------------------------------------------------------------------------
// Depth pixels are driven on the input stream and every accepted beat gets a
// predicted BGR colour, pinned by the table or computed here from the clamp,
// scale, invert and six-segment ramp rules. Output beats are compared channel
// by channel, in order. A short directed table covers reset values, range
// edges, register extremes, inverted bounds and an unused register index;
// random phases follow with changing bounds and scale and with different
// idle and stall patterns on either side.
// ----------------------------------------------------------------------------
module testbench;
  import dtrc_pkg::*;

  localparam int LATENCY     = 6;
  localparam int CYCLE_LIMIT = 250000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 180;
  localparam int MAX_PRINTS  = 50;

  // ramp arithmetic in Q.8
  localparam longint UNITY      = 65536;
  localparam longint SAT_LEVEL  = 255 * 256;
  localparam longint RAMP_STEP  = 51 * 256;
  localparam longint ROUND_HALF = 51 * 128;

  localparam logic [CFG_IDX_W-1:0]  CFG_UNUSED_IDX = 2'd3;
  localparam logic [SCALE_W-1:0]    SCALE_MAX      = 24'd16711680;
  localparam logic [3*CHAN_W-1:0]   BLACK          = '0;

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  value;     // depth for pixel rows
    logic                   pinned;
    logic [3*CHAN_W-1:0]    color;
  } row_t;

  typedef struct {
    logic [DEPTH_W-1:0]  depth;
    logic [3*CHAN_W-1:0] color;
  } colour_exp_t;

  localparam int DIRECTED_ROWS = 31;
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    // reset bounds 600 .. 3600, scale 5571
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd0,        1'b1, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd65535,    1'b1, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd3601,     1'b1, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd600,      1'b1, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd1,        1'b0, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd3600,     1'b0, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd1200,     1'b0, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd1900,     1'b0, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd2500,     1'b0, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd3100,     1'b0, BLACK},
    // full depth range
    '{ROW_WRITE, CFG_MIN_DEPTH, 24'd0,        1'b0, BLACK},
    '{ROW_WRITE, CFG_MAX_DEPTH, 24'd65535,    1'b0, BLACK},
    '{ROW_WRITE, CFG_SCALE,     24'd255,      1'b0, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd65535,    1'b0, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd1,        1'b0, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd32768,    1'b0, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd43690,    1'b0, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd21845,    1'b0, BLACK},
    // largest scale drives the inverted value below zero
    '{ROW_WRITE, CFG_SCALE,     24'd16711680, 1'b0, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd65535,    1'b1, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd1,        1'b0, BLACK},
    '{ROW_WRITE, CFG_SCALE,     24'd0,        1'b0, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd12345,    1'b1, BLACK},
    // min above max
    '{ROW_WRITE, CFG_MIN_DEPTH, 24'd5000,     1'b0, BLACK},
    '{ROW_WRITE, CFG_MAX_DEPTH, 24'd100,      1'b0, BLACK},
    '{ROW_WRITE, CFG_SCALE,     24'd300,      1'b0, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd10,       1'b0, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd200,      1'b0, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd6000,     1'b1, BLACK},
    // unused index must leave the registers alone
    '{ROW_WRITE, CFG_UNUSED_IDX, 24'd0,       1'b0, BLACK},
    '{ROW_PIXEL, CFG_MIN_DEPTH, 24'd10,       1'b0, BLACK}
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [DEPTH_W-1:0]    in_tdata   = '0;    // [15:0] depth_in
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [3*CHAN_W-1:0]   out_tdata;          // [7:0] chan0, [15:8] chan1, [23:16] chan2
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // shadow registers
  logic [DEPTH_W-1:0] lo_bound  = MIN_DEPTH_RST;
  logic [DEPTH_W-1:0] hi_bound  = MAX_DEPTH_RST;
  logic [SCALE_W-1:0] scale_q16 = SCALE_RST;

  colour_exp_t         colour_q[$];
  colour_exp_t         head;
  logic                pin_on    = 1'b0;
  logic [3*CHAN_W-1:0] pin_color = '0;
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int                  hold_left      = 0;
  int                  cycle_count    = 0;
  int                  errors         = 0;

  depth_to_rainbow_color_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // colour of one depth pixel under the current shadow registers, {r, g, b}
  function automatic logic [3*CHAN_W-1:0] rainbow_of(input logic [DEPTH_W-1:0] depth);
    logic [DEPTH_W-1:0]         span;
    logic [DEPTH_W+SCALE_W-1:0] prod;
    longint                     v;
    longint                     w;
    logic [CHAN_W-1:0]          b;
    logic [CHAN_W-1:0]          g;
    logic [CHAN_W-1:0]          r;
    b = '0;
    g = '0;
    r = '0;
    if (depth != 0 && depth < lo_bound) span = lo_bound;
    else if (depth > hi_bound)          span = '0;
    else if (depth == 0)                span = '0;
    else                                span = depth - lo_bound;
    prod = span * scale_q16;
    v = UNITY - longint'(prod >> 8);
    if (depth == 0 || v <= 0 || v >= SAT_LEVEL) begin
      // black
    end else if (v <= RAMP_STEP) begin
      b = 8'd255;
      g = 8'((v * 5) >>> 8);
    end else if (v <= 2 * RAMP_STEP) begin
      b = 8'(255 - (((v - RAMP_STEP) * 5) >>> 8));
      g = 8'd255;
    end else if (v <= 3 * RAMP_STEP) begin
      g = 8'd255;
      r = 8'(((v - 2 * RAMP_STEP) * 5) >>> 8);
    end else if (v <= 4 * RAMP_STEP) begin
      w = v - 3 * RAMP_STEP;
      g = 8'(255 - (w * 128 + ROUND_HALF) / RAMP_STEP);
      r = 8'd255;
    end else begin
      w = v - 4 * RAMP_STEP;
      g = 8'(127 - (w * 127 + ROUND_HALF) / RAMP_STEP);
      r = 8'd255;
    end
    return {r, g, b};
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_depth();
    int                 roll;
    logic [DEPTH_W-1:0] edge_val;
    roll = $urandom_range(99);
    edge_val = $urandom_range(1) ? lo_bound : hi_bound;
    if (roll < 5)       return '0;
    else if (roll < 15) return DEPTH_W'($urandom);
    else if (roll < 25) return DEPTH_W'(edge_val + $urandom_range(6) - 3);
    else if (roll < 30) return (lo_bound > 1) ? DEPTH_W'($urandom_range(1, lo_bound - 1))
                                              : DEPTH_W'($urandom);
    else                return (hi_bound >= lo_bound)
                                ? DEPTH_W'($urandom_range(lo_bound, hi_bound))
                                : DEPTH_W'($urandom);
  endfunction

  task automatic report_mismatch(input string what, input logic [DEPTH_W-1:0] depth,
                                 input logic [CHAN_W-1:0] got,
                                 input logic [CHAN_W-1:0] want);
    if (errors < MAX_PRINTS)
      $display("MISMATCH %s: depth %0d got %0d want %0d", what, depth, got, want);
    errors++;
  endtask

  task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic pinned,
                            input logic [3*CHAN_W-1:0] color);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      in_tdata  = DEPTH_W'($urandom);
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = depth;
    pin_on    = pinned;
    pin_color = color;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering and wait until the pipe has emptied
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    pin_on    = 1'b0;
    while (colour_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    case (idx)
      CFG_MIN_DEPTH: lo_bound  = value[DEPTH_W-1:0];
      CFG_MAX_DEPTH: hi_bound  = value[DEPTH_W-1:0];
      CFG_SCALE:     scale_q16 = value[SCALE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = CFG_DATA_W'($urandom);
  endtask

  // prediction on every accepted input beat
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      colour_q.push_back(colour_exp_t'{depth: in_tdata,
                                       color: pin_on ? pin_color : rainbow_of(in_tdata)});
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (colour_q.size() == 0) begin
        report_mismatch("beat with nothing expected", '0, out_tdata[7:0], '0);
      end else begin
        head = colour_q.pop_front();
        if (out_tdata[7:0] !== head.color[7:0])
          report_mismatch("chan0", head.depth, out_tdata[7:0], head.color[7:0]);
        if (out_tdata[15:8] !== head.color[15:8])
          report_mismatch("chan1", head.depth, out_tdata[15:8], head.color[15:8]);
        if (out_tdata[23:16] !== head.color[23:16])
          report_mismatch("chan2", head.depth, out_tdata[23:16], head.color[23:16]);
      end
    end
  end

  // receiver: long hold-off when asked, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [DEPTH_W-1:0] lo;
    logic [DEPTH_W-1:0] hi;
    logic [SCALE_W-1:0] sc;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        drain();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].value);
      end else begin
        send_pixel(DIRECTED[i].value[DEPTH_W-1:0], DIRECTED[i].pinned, DIRECTED[i].color);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: begin lo = '0;       hi = 16'hFFFF; end
        1: begin lo = 16'd1000; hi = 16'd1001; end
        2: begin lo = 16'd600;  hi = 16'd3600; end
        6: begin
          lo = DEPTH_W'($urandom_range(20000, 60000));
          hi = DEPTH_W'($urandom_range(0, lo - 1));
        end
        default: begin
          lo = DEPTH_W'($urandom_range(0, 50000));
          hi = DEPTH_W'(lo + $urandom_range(1, 65535 - lo));
        end
      endcase
      // scale as software would load it, except where a mismatched one is wanted
      if (phase == 5)      sc = SCALE_W'($urandom_range(0, SCALE_MAX));
      else if (phase == 6) sc = SCALE_W'($urandom_range(1, 20000));
      else                 sc = SCALE_MAX / (hi - lo);
      write_reg(CFG_MIN_DEPTH, CFG_DATA_W'(lo));
      write_reg(CFG_MAX_DEPTH, CFG_DATA_W'(hi));
      write_reg(CFG_SCALE, sc);

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_pixel(pick_depth(), 1'b0, BLACK);
        // long output hold-off while the sender keeps pushing
        if (phase == 0 && n == 30) hold_left = 300;
        if (phase == 1 && n == 90) drain();
      end
    end

    drain();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
